// ===== rtl/wsc_pkg.sv =====
// Shared types and constants for the wakeup/switch correlator.
// Used by the controller, the datapath and the top level.
package wsc_pkg;

  localparam int TIME_BITS = 64;
  localparam int CNT_BITS  = 32;
  localparam int HELD_BITS = 7;

  typedef enum logic {
    OP_WAKEUP = 1'b0,
    OP_SWITCH = 1'b1
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } wsc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } wsc_sts_t;

endpackage

// ===== rtl/wsc_ctrl.sv =====
// Sequencer for one event: accept, table scan, finish, result transfer.
// Depends on wsc_pkg.
module wsc_ctrl
  import wsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output wsc_cmd_t cmd,
  input  wsc_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN: if (sts.scan_done) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT:  if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= (state_nxt != ST_IDLE);
      out_valid_r <= (state_nxt == ST_OUT);
    end
  end

  assign in_stall   = in_stall_r;
  assign out_valid  = out_valid_r;
  assign cmd.start  = (state_r == ST_IDLE) && in_valid;
  assign cmd.scan   = (state_r == ST_SCAN);
  assign cmd.finish = (state_r == ST_FIN);

endmodule

// ===== rtl/wsc_dp.sv =====
// Datapath: pending-entry memory, scan pointers, compare logic and counters.
// Depends on wsc_pkg; sequenced by wsc_ctrl.
module wsc_dp
  import wsc_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int CPU_BITS    = 10,
  parameter int TASK_BITS   = 22
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wsc_cmd_t              cmd,
  output wsc_sts_t              sts,
  input  logic [TIME_BITS-1:0]  window_ns,
  input  logic                  in_opcode,
  input  logic [TIME_BITS-1:0]  in_event_time_ns,
  input  logic [TASK_BITS-1:0]  in_task_id,
  input  logic [CPU_BITS-1:0]   in_cpu_index,
  output logic                  out_switch_matched,
  output logic                  out_insert_dropped,
  output logic [CNT_BITS-1:0]   out_wakeup_total,
  output logic [CNT_BITS-1:0]   out_stale_wakeup_total,
  output logic [CNT_BITS-1:0]   out_matched_total,
  output logic [HELD_BITS-1:0]  out_entries_held
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = TIME_BITS + TASK_BITS + CPU_BITS + 1;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // entry layout: {time, task, cpu, matched}
  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] q_r;

  logic                 op_r;
  logic [TIME_BITS-1:0] time_r, cutoff_r;
  logic [TASK_BITS-1:0] task_r;
  logic [CPU_BITS-1:0]  cpu_r;
  logic [CW-1:0]        rd_r, wr_r, cnt_r;
  logic [AW-1:0]        idx_r;
  logic                 vld_r, found_r;
  logic [CNT_BITS-1:0]  wk_cnt_r, stale_cnt_r, match_cnt_r;

  logic                 issue;
  logic [TIME_BITS-1:0] q_time;
  logic [TASK_BITS-1:0] q_task;
  logic [CPU_BITS-1:0]  q_cpu;
  logic                 q_matched;
  logic [TIME_BITS-1:0] age;
  logic                 hit, keep, stale;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [EW-1:0]        wdata;

  assign q_time    = q_r[EW-1 -: TIME_BITS];
  assign q_task    = q_r[CPU_BITS+1 +: TASK_BITS];
  assign q_cpu     = q_r[1 +: CPU_BITS];
  assign q_matched = q_r[0];
  assign age       = time_r - q_time;

  assign issue = cmd.scan && (rd_r < cnt_r) && !found_r;
  assign sts.scan_done = !vld_r && !issue;

  always_comb begin
    hit   = 1'b0;
    keep  = 1'b0;
    stale = 1'b0;
    if (cmd.scan && vld_r && !q_matched) begin
      if (op_r == OP_WAKEUP) begin
        stale = (q_time < cutoff_r);
        keep  = !stale;
      end else begin
        hit = !found_r && (q_task == task_r) && (q_cpu == cpu_r) &&
              (time_r >= q_time) && (age <= window_ns);
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = wr_r[AW-1:0];
    wdata = {q_time, q_task, q_cpu, 1'b0};
    priority if (keep) begin
      we = 1'b1;
    end else if (hit) begin
      we    = 1'b1;
      waddr = idx_r;
      wdata = {q_time, q_task, q_cpu, 1'b1};
    end else if (cmd.finish && op_r == OP_WAKEUP && wr_r < CW'(TABLE_DEPTH)) begin
      we    = 1'b1;
      wdata = {time_r, task_r, cpu_r, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (issue) q_r <= mem[rd_r[AW-1:0]];
  end

  // event fields and output payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r     <= in_opcode;
      time_r   <= in_event_time_ns;
      task_r   <= in_task_id;
      cpu_r    <= in_cpu_index;
      cutoff_r <= (in_event_time_ns > window_ns) ? in_event_time_ns - window_ns : '0;
    end
    if (issue) idx_r <= rd_r[AW-1:0];
    if (cmd.finish) begin
      out_switch_matched <= (op_r == OP_SWITCH) && found_r;
      out_insert_dropped <= (op_r == OP_WAKEUP) && (wr_r >= CW'(TABLE_DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r        <= '0;
      wr_r        <= '0;
      cnt_r       <= '0;
      vld_r       <= 1'b0;
      found_r     <= 1'b0;
      wk_cnt_r    <= '0;
      stale_cnt_r <= '0;
      match_cnt_r <= '0;
    end else begin
      vld_r <= issue;
      if (cmd.start) begin
        rd_r    <= '0;
        wr_r    <= '0;
        found_r <= 1'b0;
      end
      if (issue) rd_r <= rd_r + 1'b1;
      if (keep) wr_r <= wr_r + 1'b1;
      if (stale) stale_cnt_r <= sat_inc(stale_cnt_r);
      if (hit) begin
        found_r     <= 1'b1;
        match_cnt_r <= sat_inc(match_cnt_r);
      end
      if (cmd.finish && op_r == OP_WAKEUP) begin
        wk_cnt_r <= sat_inc(wk_cnt_r);
        cnt_r    <= (wr_r < CW'(TABLE_DEPTH)) ? wr_r + 1'b1 : wr_r;
      end
    end
  end

  assign out_wakeup_total       = wk_cnt_r;
  assign out_stale_wakeup_total = stale_cnt_r;
  assign out_matched_total      = match_cnt_r;
  assign out_entries_held       = HELD_BITS'(cnt_r);

endmodule

// ===== rtl/wakeup_switch_correlator_unit.sv =====
// Wakeup/switch correlator: pairs task wakeups with later context switches.
// Each event passes through the table scan, the finish state and the result
// transfer. The scan reads one entry per cycle: all held entries for a wakeup,
// up to one past the hit for a switch. A new event is accepted only after the
// previous result has been transferred.
// Reset (rst_n low, synchronous) empties the table, clears all counters and
// sets window_ns to 1000000.
module wakeup_switch_correlator_unit
  import wsc_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int CPU_BITS    = 10,
  parameter int TASK_BITS   = 22
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_opcode,
  input  logic [TIME_BITS-1:0] in_event_time_ns,
  input  logic [TASK_BITS-1:0] in_task_id,
  input  logic [CPU_BITS-1:0]  in_cpu_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_switch_matched,
  output logic                 out_insert_dropped,
  output logic [CNT_BITS-1:0]  out_wakeup_total,
  output logic [CNT_BITS-1:0]  out_stale_wakeup_total,
  output logic [CNT_BITS-1:0]  out_matched_total,
  output logic [HELD_BITS-1:0] out_entries_held,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [63:0]          cfg_pwdata,
  output logic [63:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam logic [2:0]           ADDR_WINDOW  = 3'd0;
  localparam logic [TIME_BITS-1:0] WINDOW_RESET = 64'd1000000;

  logic [TIME_BITS-1:0] window_r;
  wsc_cmd_t cmd;
  wsc_sts_t sts;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_WINDOW) ? window_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_WINDOW) begin
      window_r <= cfg_pwdata;
    end
  end

  wsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  wsc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CPU_BITS    (CPU_BITS),
    .TASK_BITS   (TASK_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .window_ns              (window_r),
    .in_opcode              (in_opcode),
    .in_event_time_ns       (in_event_time_ns),
    .in_task_id             (in_task_id),
    .in_cpu_index           (in_cpu_index),
    .out_switch_matched     (out_switch_matched),
    .out_insert_dropped     (out_insert_dropped),
    .out_wakeup_total       (out_wakeup_total),
    .out_stale_wakeup_total (out_stale_wakeup_total),
    .out_matched_total      (out_matched_total),
    .out_entries_held       (out_entries_held)
  );

endmodule

// ===== test/tb.sv =====
// Self-checking bench for wakeup_switch_correlator_unit: directed and random events,
// window changes over the APB port, random idling on both channels.
// Depends on wsc_pkg and the correlator RTL only.
module tb;
  import wsc_pkg::*;

  localparam int DEPTH = 64;
  localparam int TASK_W = 22;
  localparam int CPU_W = 10;
  localparam logic [2:0] WINDOW_ADDR = 3'd0;
  localparam logic [63:0] WIN_RESET = 64'd1000000;
  localparam logic [63:0] WIN_MAX = '1;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    op_t op;
    logic [63:0] t;
    logic [TASK_W-1:0] tsk;
    logic [CPU_W-1:0] cpu;
  } evt_t;

  typedef struct {
    logic matched;
    logic dropped;
    logic [31:0] wakeups;
    logic [31:0] stale;
    logic [31:0] corrs;
    logic [6:0] held;
  } tally_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_opcode;
  logic [63:0] in_event_time_ns;
  logic [TASK_W-1:0] in_task_id;
  logic [CPU_W-1:0] in_cpu_index;
  logic out_valid, out_stall, out_switch_matched, out_insert_dropped;
  logic [31:0] out_wakeup_total, out_stale_wakeup_total, out_matched_total;
  logic [6:0] out_entries_held;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0] cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;

  wakeup_switch_correlator_unit DUT (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // predictor state
  logic [63:0] win_ns;
  logic [63:0] pend_time[DEPTH];
  logic [TASK_W-1:0] pend_task[DEPTH];
  logic [CPU_W-1:0] pend_cpu[DEPTH];
  logic pend_hit[DEPTH];
  int pend_cnt;
  logic [31:0] wake_cnt, stale_cnt, match_cnt;

  evt_t pending_evts[$];
  tally_t expected_tallies[$];
  int errors;
  int cycles;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  task automatic correlate_event(input evt_t e);
    tally_t r;
    logic [63:0] cutoff;
    int wr;
    r.matched = 1'b0;
    r.dropped = 1'b0;
    if (e.op == OP_WAKEUP) begin
      cutoff = (e.t > win_ns) ? e.t - win_ns : 64'd0;
      wake_cnt = sat_inc(wake_cnt);
      wr = 0;
      for (int rd = 0; rd < pend_cnt; rd++) begin
        if (pend_hit[rd]) continue;
        if (pend_time[rd] < cutoff) begin
          stale_cnt = sat_inc(stale_cnt);
          continue;
        end
        pend_time[wr] = pend_time[rd];
        pend_task[wr] = pend_task[rd];
        pend_cpu[wr] = pend_cpu[rd];
        pend_hit[wr] = 1'b0;
        wr++;
      end
      pend_cnt = wr;
      if (pend_cnt >= DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        pend_time[pend_cnt] = e.t;
        pend_task[pend_cnt] = e.tsk;
        pend_cpu[pend_cnt] = e.cpu;
        pend_hit[pend_cnt] = 1'b0;
        pend_cnt++;
      end
    end else begin
      for (int i = 0; i < pend_cnt; i++) begin
        if (!pend_hit[i] && pend_task[i] == e.tsk && pend_cpu[i] == e.cpu &&
            e.t >= pend_time[i] && (e.t - pend_time[i]) <= win_ns) begin
          pend_hit[i] = 1'b1;
          match_cnt = sat_inc(match_cnt);
          r.matched = 1'b1;
          break;
        end
      end
    end
    r.wakeups = wake_cnt;
    r.stale = stale_cnt;
    r.corrs = match_cnt;
    r.held = pend_cnt[6:0];
    expected_tallies = {expected_tallies, r};
  endtask

  // input driver
  int send_gap;
  logic send_burst;
  logic in_taken;

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      correlate_event('{op_t'(in_opcode), in_event_time_ns, in_task_id, in_cpu_index});
    end
  end

  always @(negedge clk) begin
    evt_t e;
    if (!rst_n || (in_valid && !in_taken)) begin
      // hold the stalled transfer
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_evts.size() > 0) begin
      e = pending_evts.pop_front();
      in_valid <= 1'b1;
      in_opcode <= e.op;
      in_event_time_ns <= e.t;
      in_task_id <= e.tsk;
      in_cpu_index <= e.cpu;
      if ($urandom_range(0, 60) == 0) send_burst <= !send_burst;
      send_gap <= send_burst ? 0 : $urandom_range(0, 11);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result monitor
  int recv_wait;
  logic recv_burst;

  always @(negedge clk) begin
    if (recv_wait > 0) begin
      out_stall <= 1'b1;
      recv_wait <= recv_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    tally_t x;
    logic bad;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if ($urandom_range(0, 60) == 0) recv_burst <= !recv_burst;
      recv_wait <= recv_burst ? 0 : $urandom_range(0, 11);
      if (expected_tallies.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result transfer at cycle %0d", cycles);
      end else begin
        x = expected_tallies.pop_front();
        bad = (x.matched !== out_switch_matched) || (x.dropped !== out_insert_dropped) ||
              (x.wakeups !== out_wakeup_total) || (x.stale !== out_stale_wakeup_total) ||
              (x.corrs !== out_matched_total) || (x.held !== out_entries_held);
        if (bad) begin
          errors <= errors + 1;
          if (errors < 10) begin
            $display("mismatch cycle %0d: exp m=%0b d=%0b w=%0d s=%0d c=%0d h=%0d",
                     cycles, x.matched, x.dropped, x.wakeups, x.stale, x.corrs, x.held);
            $display("                   got m=%0b d=%0b w=%0d s=%0d c=%0d h=%0d",
                     out_switch_matched, out_insert_dropped, out_wakeup_total,
                     out_stale_wakeup_total, out_matched_total, out_entries_held);
          end
        end
      end
    end
  end

  // stimulus
  logic [63:0] now_ns;
  evt_t recent[$];

  task automatic push_evt(input op_t op, input logic [63:0] t,
                          input logic [TASK_W-1:0] tsk, input logic [CPU_W-1:0] cpu);
    evt_t e;
    e = '{op, t, tsk, cpu};
    pending_evts = {pending_evts, e};
    if (op == OP_WAKEUP) begin
      recent = {recent, e};
      if (recent.size() > 16) void'(recent.pop_front());
    end
  endtask

  task automatic wait_idle();
    wait (pending_evts.size() == 0 && !in_valid && expected_tallies.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_window(input logic [63:0] w);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= WINDOW_ADDR;
    cfg_pwdata <= w;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    win_ns = w;
  endtask

  task automatic random_phase(input int n, input int wake_pct);
    logic [63:0] step, off;
    evt_t pick;
    step = (win_ns > 64'd10000) ? 64'd20000 : win_ns * 2 + 3;
    for (int k = 0; k < n; k++) begin
      now_ns = now_ns + ({$urandom, $urandom} % (step + 1));
      if ($urandom_range(0, 99) < 5) begin
        // noise: fields over their full range
        push_evt(op_t'($urandom_range(0, 1)), {$urandom, $urandom},
                 TASK_W'($urandom), CPU_W'($urandom));
      end else if ($urandom_range(0, 99) < wake_pct || recent.size() == 0) begin
        push_evt(OP_WAKEUP, now_ns, TASK_W'($urandom_range(0, 7)),
                 CPU_W'($urandom_range(0, 3)));
      end else if ($urandom_range(0, 3) != 0) begin
        pick = recent[$urandom_range(0, recent.size() - 1)];
        case ($urandom_range(0, 4))
          0: off = 64'd0;
          1: off = win_ns;
          2: off = win_ns + 1;
          3: off = -64'd1;
          default: off = (win_ns < 64'd1000) ? {$urandom, $urandom} % (win_ns + 1)
                                             : 64'($urandom_range(0, 1000));
        endcase
        push_evt(OP_SWITCH, pick.t + off, pick.tsk, pick.cpu);
      end else begin
        push_evt(OP_SWITCH, now_ns, TASK_W'($urandom_range(0, 7)),
                 CPU_W'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    logic [63:0] windows[8];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = 1'b0;
    in_event_time_ns = '0;
    in_task_id = '0;
    in_cpu_index = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_gap = 0;
    send_burst = 1'b0;
    recv_wait = 0;
    recv_burst = 1'b0;
    in_taken = 1'b0;
    errors = 0;
    cycles = 0;
    win_ns = WIN_RESET;
    pend_cnt = 0;
    wake_cnt = '0;
    stale_cnt = '0;
    match_cnt = '0;
    for (int i = 0; i < DEPTH; i++) pend_hit[i] = 1'b0;
    now_ns = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: age zero, future wakeup, window edge, stale prune, extremes
    push_evt(OP_WAKEUP, 64'd0, '0, '0);
    push_evt(OP_SWITCH, 64'd0, '0, '0);
    push_evt(OP_WAKEUP, 64'd100, '1, '1);
    push_evt(OP_SWITCH, 64'd50, '1, '1);
    push_evt(OP_SWITCH, 64'd100 + WIN_RESET, '1, '1);
    push_evt(OP_WAKEUP, 64'd200, 22'd5, 10'd3);
    push_evt(OP_SWITCH, 64'd201 + WIN_RESET, 22'd5, 10'd3);
    push_evt(OP_SWITCH, 64'd300, 22'd5, 10'd2);
    push_evt(OP_SWITCH, 64'd300, 22'd4, 10'd3);
    push_evt(OP_WAKEUP, 64'd3000000, 22'd7, 10'd1);
    push_evt(OP_WAKEUP, WIN_MAX, 22'd1, 10'd1);
    push_evt(OP_SWITCH, WIN_MAX, 22'd1, 10'd1);
    push_evt(OP_WAKEUP, 64'd5, 22'h2AAAAA, 10'h155);
    push_evt(OP_SWITCH, 64'd5, 22'h2AAAAA, 10'h155);
    wait_idle();

    windows = '{WIN_RESET, 64'd0, WIN_MAX, 64'd40, 64'd3000, WIN_MAX,
                {$urandom, $urandom}, WIN_RESET};
    for (int p = 0; p < 8; p++) begin
      write_window(windows[p]);
      recent.delete();
      random_phase(230, (windows[p] == WIN_MAX) ? 85 : 55);
      wait_idle();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
